@@ design/assert_macros.svh @@
// assertion helpers, clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tdalu_pkg.sv @@
package tdalu_pkg;

  // operation codes
  localparam logic [3:0] CMD_ADD = 4'd0;
  localparam logic [3:0] CMD_SUB = 4'd1;
  localparam logic [3:0] CMD_MUL = 4'd2;
  localparam logic [3:0] CMD_DIV = 4'd3;
  localparam logic [3:0] CMD_MOD = 4'd4;
  localparam logic [3:0] CMD_NEG = 4'd5;
  localparam logic [3:0] CMD_EQ  = 4'd6;
  localparam logic [3:0] CMD_NE  = 4'd7;
  localparam logic [3:0] CMD_LE  = 4'd8;
  localparam logic [3:0] CMD_LT  = 4'd9;
  localparam logic [3:0] CMD_GE  = 4'd10;
  localparam logic [3:0] CMD_GT  = 4'd11;

  // operand kinds
  localparam logic [1:0] KIND_NULL = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;
  localparam logic [1:0] KIND_DEC  = 2'd2;

  localparam logic [31:0] DEC_SCALE = 32'd1000;

  // ceil(2^42 / 1000), exact floor(n/1000) for any 32-bit n
  localparam logic [32:0] RECIP_1000 = 33'd4398046512;
  localparam int          RECIP_SH   = 42;
  localparam int          IQ_W       = 22;

  localparam int DVD_W = 63;
  localparam int DSR_W = 32;

  typedef enum logic [1:0] {
    FIN_DIRECT,
    FIN_QUOT,
    FIN_REM
  } fin_t;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [1:0]         ka;
    logic [1:0]         kb;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] ia;
    logic signed [31:0] ib;
    logic signed [31:0] da;
    logic signed [31:0] db;
  } opnd_t;

  typedef struct packed {
    fin_t        fin;
    logic [1:0]  rk;
    logic [31:0] rv;
    logic        is_true;
    logic        err;
    logic        qneg;
    logic        rneg;
    logic        rnd;
  } side_t;

  typedef struct packed {
    logic [DVD_W-1:0] dvd;
    logic [DSR_W-1:0] dsr;
    side_t            side;
  } div_in_t;

  typedef struct packed {
    logic [31:0]      quo;
    logic [DSR_W-1:0] rem;
    logic [DSR_W-1:0] dsr;
    side_t            side;
  } div_out_t;

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // decimal view: integers scaled by 1000, wrapped
  function automatic logic [31:0] dec_view(logic [1:0] k, logic [31:0] v);
    logic [31:0] r;
    case (k)
      KIND_DEC: r = v;
      KIND_INT: r = v * DEC_SCALE;
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ design/tagged_decimal_alu.sv @@
// throughput: one beat per cycle while the output is not stalled; the depth is set by the 63-stage restoring divider,
//   one quotient bit per stage, behind four operand and multiply stages
// a stalled output freezes the whole pipe; the first stage still fills while empty
// reset: synchronous, active low, clears all valid bits; data registers are not reset
`include "assert_macros.svh"

module tagged_decimal_alu import tdalu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // cmd[3:0], a_value[35:4], b_value[67:36], zero pad
  input  logic [3:0]  in_tuser,   // a_kind[1:0], b_kind[3:2]
  // result beat
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // result_value[31:0], is_true[32], error_code[33], zero pad
  output logic [1:0]  out_tuser   // result_kind[1:0]
);

  logic        adv;
  logic        prep_valid, exec_valid, div_valid;
  opnd_t       prep_opnd;
  div_in_t     exec_div;
  div_out_t    div_res;

  logic        out_valid_r;
  logic [1:0]  out_rk_r;
  logic [31:0] out_rv_r;
  logic        out_t_r;
  logic        out_err_r;

  logic [31:0] rv_fin;
  logic        round_up;

  // whole pipe moves when the output slot is free or being drained
  assign adv = !out_valid_r || out_tready;

  // operand decode, kind views, integer view of decimals
  tdalu_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cmd       (in_tdata[3:0]),
    .a_kind    (in_tuser[1:0]),
    .a_value   (in_tdata[35:4]),
    .b_kind    (in_tuser[3:2]),
    .b_value   (in_tdata[67:36]),
    .out_valid (prep_valid),
    .out_opnd  (prep_opnd)
  );

  // add, sub, negate, compares, multiply, divider setup
  tdalu_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (prep_valid),
    .in_opnd   (prep_opnd),
    .out_valid (exec_valid),
    .out_div   (exec_div)
  );

  // shared divider: decimal multiply rescale, decimal divide, int divide and modulo
  tdalu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (exec_valid),
    .in_div    (exec_div),
    .out_valid (div_valid),
    .out_div   (div_res)
  );

  // half-up on the next digit: remainder at least half the divisor, positives only
  assign round_up = div_res.side.rnd &&
                    ({div_res.rem, 1'b0} >= {1'b0, div_res.dsr});

  always_comb begin
    case (div_res.side.fin)
      FIN_QUOT: rv_fin = div_res.side.qneg ? (32'd0 - div_res.quo)
                                           : (div_res.quo + 32'(round_up));
      FIN_REM:  rv_fin = div_res.side.rneg ? (32'd0 - div_res.rem) : div_res.rem;
      default:  rv_fin = div_res.side.rv;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= div_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rk_r  <= div_res.side.rk;
      out_rv_r  <= rv_fin;
      out_t_r   <= div_res.side.is_true;
      out_err_r <= div_res.side.err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rk_r;
  assign out_tdata  = {6'd0, out_err_r, out_t_r, out_rv_r};

  // a divide-by-zero beat carries nothing else
  `ASSERT_IMPLIES(a_err_clean, out_valid_r && out_err_r, out_rk_r == KIND_NULL && out_rv_r == 32'd0 && !out_t_r, "error beat with payload")
  // a true compare has no kind and no error
  `ASSERT_IMPLIES(a_true_cmp, out_valid_r && out_t_r, out_rk_r == KIND_NULL && !out_err_r, "true flag outside compare")
  // an empty output slot always takes the divider result
  `ASSERT_NEXT(a_out_fill, !out_valid_r && div_valid, out_valid_r, "result dropped at output")

endmodule

@@ design/tdalu_prep.sv @@
module tdalu_prep import tdalu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         cmd,
  input  logic [1:0]         a_kind,
  input  logic signed [31:0] a_value,
  input  logic [1:0]         b_kind,
  input  logic signed [31:0] b_value,
  output logic               out_valid,
  output opnd_t              out_opnd
);

  logic              s1_valid_r;
  logic [3:0]        s1_cmd_r;
  logic [1:0]        s1_ka_r, s1_kb_r;
  logic [31:0]       s1_a_r, s1_b_r, s1_da_r, s1_db_r;
  logic [IQ_W-1:0]   s1_qa_r, s1_qb_r;
  logic              s2_valid_r;
  opnd_t             s2_opnd_r;

  logic              en1;
  logic [1:0]        ka_n, kb_n;
  logic [64:0]       pa, pb;
  opnd_t             s2_nxt;

  assign en1      = adv || !s1_valid_r;
  assign in_ready = en1;

  // kind code 3 behaves as null
  assign ka_n = (a_kind == KIND_INT || a_kind == KIND_DEC) ? a_kind : KIND_NULL;
  assign kb_n = (b_kind == KIND_INT || b_kind == KIND_DEC) ? b_kind : KIND_NULL;

  // magnitude / 1000 by reciprocal
  assign pa = 65'(abs32(a_value)) * 65'(RECIP_1000);
  assign pb = 65'(abs32(b_value)) * 65'(RECIP_1000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r <= in_valid;
      if (adv) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_cmd_r <= cmd;
      s1_ka_r  <= ka_n;
      s1_kb_r  <= kb_n;
      s1_a_r   <= a_value;
      s1_b_r   <= b_value;
      s1_da_r  <= dec_view(ka_n, a_value);
      s1_db_r  <= dec_view(kb_n, b_value);
      s1_qa_r  <= pa[RECIP_SH +: IQ_W];
      s1_qb_r  <= pb[RECIP_SH +: IQ_W];
    end
    if (adv) s2_opnd_r <= s2_nxt;
  end

  always_comb begin
    s2_nxt.cmd = s1_cmd_r;
    s2_nxt.ka  = s1_ka_r;
    s2_nxt.kb  = s1_kb_r;
    s2_nxt.a   = s1_a_r;
    s2_nxt.b   = s1_b_r;
    s2_nxt.da  = s1_da_r;
    s2_nxt.db  = s1_db_r;
    case (s1_ka_r)
      KIND_INT: s2_nxt.ia = s1_a_r;
      KIND_DEC: s2_nxt.ia = s1_a_r[31] ? (32'd0 - 32'(s1_qa_r)) : 32'(s1_qa_r);
      default:  s2_nxt.ia = '0;
    endcase
    case (s1_kb_r)
      KIND_INT: s2_nxt.ib = s1_b_r;
      KIND_DEC: s2_nxt.ib = s1_b_r[31] ? (32'd0 - 32'(s1_qb_r)) : 32'(s1_qb_r);
      default:  s2_nxt.ib = '0;
    endcase
  end

  assign out_valid = s2_valid_r;
  assign out_opnd  = s2_opnd_r;

endmodule

@@ design/tdalu_exec.sv @@
module tdalu_exec import tdalu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  logic    in_valid,
  input  opnd_t   in_opnd,
  output logic    out_valid,
  output div_in_t out_div
);

  logic               s3_valid_r;
  logic signed [63:0] s3_prod_r;
  side_t              s3_side_r;
  logic [DVD_W-1:0]   s3_dvd_r;
  logic [DSR_W-1:0]   s3_dsr_r;
  logic               s3_from_prod_r;
  logic               s3_prod_lo_r;
  logic               s4_valid_r;
  div_in_t            s4_div_r;

  logic               dec;
  logic signed [31:0] mx, my;
  logic signed [63:0] prod_c;
  logic               eq_ab, le_ab, le_ba;
  side_t              side_c;
  logic [DVD_W-1:0]   dvd_c;
  logic [DSR_W-1:0]   dsr_c;
  logic               from_prod_c, prod_lo_c;
  logic [41:0]        mda;
  logic [41:0]        da_k;
  logic [63:0]        pabs;
  div_in_t            s4_nxt;

  assign dec = (in_opnd.ka == KIND_DEC) || (in_opnd.kb == KIND_DEC);
  assign mx  = dec ? in_opnd.da : in_opnd.ia;
  assign my  = dec ? in_opnd.db : in_opnd.ib;
  assign prod_c = 64'(mx) * 64'(my);

  // |da| * 1000
  assign mda  = 42'(abs32(in_opnd.da));
  assign da_k = (mda << 10) - (mda << 4) - (mda << 3);

  // unlike non-decimal kinds by kind code, same-kind numbers by value
  always_comb begin
    if (in_opnd.ka != in_opnd.kb) begin
      if (dec) begin
        eq_ab = in_opnd.da == in_opnd.db;
        le_ab = in_opnd.da <= in_opnd.db;
        le_ba = in_opnd.db <= in_opnd.da;
      end else begin
        eq_ab = 1'b0;
        le_ab = in_opnd.ka < in_opnd.kb;
        le_ba = in_opnd.kb < in_opnd.ka;
      end
    end else if (in_opnd.ka == KIND_NULL) begin
      eq_ab = 1'b1;
      le_ab = 1'b1;
      le_ba = 1'b1;
    end else begin
      eq_ab = in_opnd.a == in_opnd.b;
      le_ab = in_opnd.a <= in_opnd.b;
      le_ba = in_opnd.b <= in_opnd.a;
    end
  end

  always_comb begin
    side_c      = '0;
    side_c.fin  = FIN_DIRECT;
    dvd_c       = '0;
    dsr_c       = '0;
    from_prod_c = 1'b0;
    prod_lo_c   = 1'b0;
    unique case (in_opnd.cmd)
      CMD_ADD, CMD_SUB: begin
        side_c.rk = dec ? KIND_DEC : KIND_INT;
        if (in_opnd.cmd == CMD_ADD) side_c.rv = mx + my;
        else side_c.rv = mx - my;
      end
      CMD_MUL: begin
        if (dec) begin
          side_c.fin  = FIN_QUOT;
          side_c.rk   = KIND_DEC;
          side_c.qneg = in_opnd.da[31] ^ in_opnd.db[31];
          side_c.rnd  = !(in_opnd.da[31] ^ in_opnd.db[31]);
          dsr_c       = DEC_SCALE;
          from_prod_c = 1'b1;
        end else begin
          side_c.rk = KIND_INT;
          prod_lo_c = 1'b1;
        end
      end
      CMD_DIV: begin
        if (dec) begin
          if (in_opnd.db == '0) begin
            side_c.err = 1'b1;
          end else begin
            side_c.fin  = FIN_QUOT;
            side_c.rk   = KIND_DEC;
            side_c.qneg = in_opnd.da[31] ^ in_opnd.db[31];
            side_c.rnd  = !(in_opnd.da[31] ^ in_opnd.db[31]);
            dvd_c       = DVD_W'(da_k);
            dsr_c       = abs32(in_opnd.db);
          end
        end else begin
          if (in_opnd.ib == '0) begin
            side_c.err = 1'b1;
          end else begin
            side_c.fin  = FIN_QUOT;
            side_c.rk   = KIND_INT;
            side_c.qneg = in_opnd.ia[31] ^ in_opnd.ib[31];
            dvd_c       = DVD_W'(abs32(in_opnd.ia));
            dsr_c       = abs32(in_opnd.ib);
          end
        end
      end
      CMD_MOD: begin
        if (in_opnd.ib == '0) begin
          side_c.err = 1'b1;
        end else begin
          side_c.fin  = FIN_REM;
          side_c.rk   = KIND_INT;
          side_c.rneg = in_opnd.ia[31];
          dvd_c       = DVD_W'(abs32(in_opnd.ia));
          dsr_c       = abs32(in_opnd.ib);
        end
      end
      CMD_NEG: begin
        if (in_opnd.ka == KIND_DEC) begin
          side_c.rk = KIND_DEC;
          side_c.rv = 32'd0 - in_opnd.a;
        end else begin
          side_c.rk = KIND_INT;
          side_c.rv = 32'd0 - in_opnd.ia;
        end
      end
      CMD_EQ:  side_c.is_true = eq_ab;
      CMD_NE:  side_c.is_true = !eq_ab;
      CMD_LE:  side_c.is_true = le_ab;
      CMD_LT:  side_c.is_true = !le_ba;
      CMD_GE:  side_c.is_true = le_ba;
      CMD_GT:  side_c.is_true = !le_ab;
      default: side_c.fin = FIN_DIRECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= in_valid;
      s4_valid_r <= s3_valid_r;
    end
  end

  assign pabs = s3_prod_r[63] ? (64'd0 - s3_prod_r) : s3_prod_r;

  always_comb begin
    s4_nxt.dvd  = s3_from_prod_r ? pabs[DVD_W-1:0] : s3_dvd_r;
    s4_nxt.dsr  = s3_dsr_r;
    s4_nxt.side = s3_side_r;
    if (s3_prod_lo_r) s4_nxt.side.rv = s3_prod_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_prod_r      <= prod_c;
      s3_side_r      <= side_c;
      s3_dvd_r       <= dvd_c;
      s3_dsr_r       <= dsr_c;
      s3_from_prod_r <= from_prod_c;
      s3_prod_lo_r   <= prod_lo_c;
      s4_div_r       <= s4_nxt;
    end
  end

  assign out_valid = s4_valid_r;
  assign out_div   = s4_div_r;

endmodule

@@ design/tdalu_div.sv @@
module tdalu_div import tdalu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     in_valid,
  input  div_in_t  in_div,
  output logic     out_valid,
  output div_out_t out_div
);

  // one restoring step per stage, dividend msb first
  logic             v_r   [DVD_W];
  logic [DVD_W-1:0] dvd_r [DVD_W];
  logic [DSR_W-1:0] rem_r [DVD_W];
  logic [31:0]      quo_r [DVD_W];
  logic [DSR_W-1:0] dsr_r [DVD_W];
  side_t            side_r[DVD_W];

  for (genvar k = 0; k < DVD_W; k++) begin : g_step
    logic             v_i;
    logic [DVD_W-1:0] d_i;
    logic [DSR_W-1:0] r_i, s_i;
    logic [31:0]      q_i;
    side_t            sd_i;
    logic [DSR_W:0]   trial;
    logic             take;

    if (k == 0) begin : g_head
      assign v_i  = in_valid;
      assign d_i  = in_div.dvd;
      assign r_i  = '0;
      assign q_i  = '0;
      assign s_i  = in_div.dsr;
      assign sd_i = in_div.side;
    end else begin : g_body
      assign v_i  = v_r[k-1];
      assign d_i  = dvd_r[k-1];
      assign r_i  = rem_r[k-1];
      assign q_i  = quo_r[k-1];
      assign s_i  = dsr_r[k-1];
      assign sd_i = side_r[k-1];
    end

    assign trial = {r_i, d_i[DVD_W-1]};
    assign take  = trial >= {1'b0, s_i};

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (adv) v_r[k] <= v_i;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dvd_r[k]  <= d_i << 1;
        rem_r[k]  <= take ? DSR_W'(trial - {1'b0, s_i}) : DSR_W'(trial);
        quo_r[k]  <= {q_i[30:0], take};
        dsr_r[k]  <= s_i;
        side_r[k] <= sd_i;
      end
    end
  end

  assign out_valid    = v_r[DVD_W-1];
  assign out_div.quo  = quo_r[DVD_W-1];
  assign out_div.rem  = rem_r[DVD_W-1];
  assign out_div.dsr  = dsr_r[DVD_W-1];
  assign out_div.side = side_r[DVD_W-1];

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import tdalu_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // cmd[3:0], a_value[35:4], b_value[67:36], zero pad
  logic [3:0]  in_tuser;   // a_kind[1:0], b_kind[3:2]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // result_value[31:0], is_true[32], error_code[33], zero pad
  logic [1:0]  out_tuser;  // result_kind[1:0]

  typedef struct packed {
    logic [1:0]  rk;
    logic [31:0] rv;
    logic        t;
    logic        err;
  } alu_res_t;

  alu_res_t result_q[$];
  int       n_fail;
  int       send_idle_pct;
  int       recv_idle_pct;
  bit       hold_off;
  int       quiet_cycles;

  tagged_decimal_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [1:0] norm_kind(logic [1:0] k);
    return (k == 2'd3) ? KIND_NULL : k;
  endfunction

  function automatic longint to_dec(logic [1:0] k, logic signed [31:0] v);
    logic signed [31:0] w;
    w = v * 32'sd1000;
    if (k == KIND_DEC) return longint'(v);
    if (k == KIND_INT) return longint'(w);
    return 0;
  endfunction

  function automatic longint to_int(logic [1:0] k, logic signed [31:0] v);
    if (k == KIND_INT) return longint'(v);
    if (k == KIND_DEC) return longint'(v) / 1000;
    return 0;
  endfunction

  function automatic longint round_half(longint x);
    if (x % 10 >= 5) return x / 10 + 1;
    return x / 10;
  endfunction

  function automatic bit tag_eq(logic [1:0] ka, logic signed [31:0] a,
                                logic [1:0] kb, logic signed [31:0] b);
    if (ka != kb) begin
      if (ka == KIND_DEC || kb == KIND_DEC) return to_dec(ka, a) == to_dec(kb, b);
      return 1'b0;
    end
    if (ka == KIND_NULL) return 1'b1;
    return a == b;
  endfunction

  function automatic bit tag_le(logic [1:0] ka, logic signed [31:0] a,
                                logic [1:0] kb, logic signed [31:0] b);
    if (ka != kb) begin
      if (ka == KIND_DEC || kb == KIND_DEC) return to_dec(ka, a) <= to_dec(kb, b);
      return ka < kb;
    end
    if (ka == KIND_NULL) return 1'b1;
    return a <= b;
  endfunction

  function automatic alu_res_t alu_predict(logic [3:0] cmd, logic [1:0] ka_raw,
                                           logic signed [31:0] a, logic [1:0] kb_raw,
                                           logic signed [31:0] b);
    alu_res_t r;
    logic [1:0] ka, kb;
    bit dec;
    longint x, y;
    r = '0;
    ka = norm_kind(ka_raw);
    kb = norm_kind(kb_raw);
    dec = (ka == KIND_DEC) || (kb == KIND_DEC);
    case (cmd)
      CMD_ADD, CMD_SUB: begin
        x = dec ? to_dec(ka, a) : to_int(ka, a);
        y = dec ? to_dec(kb, b) : to_int(kb, b);
        r.rk = dec ? KIND_DEC : KIND_INT;
        r.rv = (cmd == CMD_ADD) ? 32'(x + y) : 32'(x - y);
      end
      CMD_MUL: begin
        if (dec) begin
          x = to_dec(ka, a) * to_dec(kb, b);
          r.rk = KIND_DEC;
          r.rv = 32'(round_half(x / 100));
        end else begin
          r.rk = KIND_INT;
          r.rv = 32'(to_int(ka, a) * to_int(kb, b));
        end
      end
      CMD_DIV: begin
        y = dec ? to_dec(kb, b) : to_int(kb, b);
        if (y == 0) r.err = 1'b1;
        else if (dec) begin
          r.rk = KIND_DEC;
          r.rv = 32'(round_half(to_dec(ka, a) * 10000 / y));
        end else begin
          r.rk = KIND_INT;
          r.rv = 32'(to_int(ka, a) / y);
        end
      end
      CMD_MOD: begin
        y = to_int(kb, b);
        if (y == 0) r.err = 1'b1;
        else begin
          r.rk = KIND_INT;
          r.rv = 32'(to_int(ka, a) % y);
        end
      end
      CMD_NEG: begin
        if (ka == KIND_DEC) begin
          r.rk = KIND_DEC;
          r.rv = 32'(-longint'(a));
        end else begin
          r.rk = KIND_INT;
          r.rv = 32'(-to_int(ka, a));
        end
      end
      CMD_EQ: r.t = tag_eq(ka, a, kb, b);
      CMD_NE: r.t = !tag_eq(ka, a, kb, b);
      CMD_LE: r.t = tag_le(ka, a, kb, b);
      CMD_LT: r.t = !tag_le(kb, b, ka, a);
      CMD_GE: r.t = tag_le(kb, b, ka, a);
      CMD_GT: r.t = !tag_le(ka, a, kb, b);
      default: ;
    endcase
    return r;
  endfunction

  // one input beat, held until accepted; valid stays up for a following beat
  task automatic send_op(logic [3:0] cmd, logic [1:0] ka, logic [31:0] a,
                         logic [1:0] kb, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, b, a, cmd};
    in_tuser  <= {kb, ka};
    result_q = {result_q, alu_predict(cmd, ka, a, kb, b)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(2000)) - 32'd1000;
      3: return 32'($urandom_range(20)) - 32'd10;
      4: return $urandom_range(1) ? 32'hffff_ffff : 32'd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [3:0] c;
    send_op(CMD_ADD, KIND_INT, 32'h7fff_ffff, KIND_INT, 32'd1);
    send_op(CMD_SUB, KIND_INT, 32'h8000_0000, KIND_DEC, 32'd1);
    send_op(CMD_MUL, KIND_DEC, 32'h7fff_ffff, KIND_DEC, 32'h7fff_ffff);
    send_op(CMD_MUL, KIND_DEC, -32'sd1500, KIND_DEC, 32'd1);
    send_op(CMD_MUL, KIND_DEC, 32'd1500, KIND_DEC, 32'd1);
    send_op(CMD_DIV, KIND_DEC, 32'd1000, KIND_DEC, 32'd0);
    send_op(CMD_DIV, KIND_INT, 32'd5, KIND_DEC, 32'd999);
    send_op(CMD_DIV, KIND_INT, 32'h8000_0000, KIND_INT, 32'hffff_ffff);
    send_op(CMD_DIV, KIND_DEC, 32'h8000_0000, KIND_DEC, 32'd1);
    send_op(CMD_MOD, KIND_INT, 32'h8000_0000, KIND_INT, 32'hffff_ffff);
    send_op(CMD_MOD, KIND_INT, 32'd7, KIND_DEC, 32'd999);
    send_op(CMD_NEG, KIND_DEC, 32'h8000_0000, KIND_INT, 32'd3);
    send_op(CMD_NEG, 2'd3, 32'd9, KIND_NULL, 32'd0);
    send_op(CMD_NEG, KIND_INT, 32'h8000_0000, KIND_NULL, 32'd0);
    send_op(CMD_EQ, KIND_NULL, 32'd1, 2'd3, 32'd2);
    send_op(CMD_EQ, KIND_INT, 32'd0, KIND_NULL, 32'd0);
    send_op(CMD_LT, KIND_NULL, 32'd5, KIND_INT, 32'hffff_ffff);
    send_op(CMD_GE, KIND_INT, 32'd2, KIND_DEC, 32'd2000);
    for (int i = 0; i < 6; i++) begin
      c = CMD_EQ + 4'(i);
      send_op(c, KIND_INT, 32'd3, KIND_INT, 32'd4);
    end
    send_op(4'd12, KIND_INT, 32'd3, KIND_INT, 32'd4);
    send_op(4'd15, KIND_DEC, 32'hffff_ffff, 2'd3, 32'hffff_ffff);
  endtask

  task automatic test_random(int n);
    logic [3:0] c;
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(11));
      send_op(c, 2'($urandom_range(3)), rand_value(), 2'($urandom_range(3)), rand_value());
    end
  endtask

  // receiver stays off long enough for the pipe to fill and stall input
  task automatic test_backpressure();
    recv_idle_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        test_random(150);
        in_tvalid <= 1'b0;
      end
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  task automatic drain();
    while (result_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // checker
  always @(posedge clk) begin
    if (rst_n) out_tready <= hold_off ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        $display("%0t unexpected result: actual %h/%h", $time, out_tuser, out_tdata);
        n_fail++;
      end else begin
        alu_res_t e;
        e = result_q.pop_front();
        if (out_tuser != e.rk || out_tdata[31:0] != e.rv || out_tdata[32] != e.t ||
            out_tdata[33] != e.err) begin
          $display("%0t mismatch: expected kind %0d value %h true %b err %b, actual %0d %h %b %b",
                   $time, e.rk, e.rv, e.t, e.err, out_tuser, out_tdata[31:0],
                   out_tdata[32], out_tdata[33]);
          n_fail++;
        end
      end
    end
  end

  // watchdog on stalled progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tagged_decimal_alu verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    n_fail = 0;
    hold_off = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 8;
    recv_idle_pct = 87;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(550);
    send_idle_pct = 87;
    recv_idle_pct = 8;
    test_random(550);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(575);
    test_backpressure();
    drain();
    if (n_fail == 0) $display("tagged_decimal_alu verification clean");
    else $display("tagged_decimal_alu verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/tdalu_pkg.sv
design/tdalu_prep.sv
design/tdalu_exec.sv
design/tdalu_div.sv
design/tagged_decimal_alu.sv
tb/sv/testbench.sv
